// ===== design/iptl_pkg.sv =====
// shared types and constants for the inverted page table
package iptl_pkg;

    localparam int PID_IN_W     = 16;
    localparam int PAGE_IN_W    = 20;
    localparam int OFFSET_W     = 16;
    localparam int PHYS_W       = 22;
    localparam int FRAME_IDX_W  = 6;
    localparam int CFG_W        = 17;
    localparam int STAMP_W      = 32;
    localparam int RANK_W       = 2;
    localparam int KEY_W        = RANK_W + STAMP_W;

    localparam logic [CFG_W-1:0]   FRAME_SIZE_RESET = 17'd4096;
    localparam logic [STAMP_W-1:0] STAMP_MAX        = {STAMP_W{1'b1}};

    // search ranks, lowest wins
    localparam logic [RANK_W-1:0] RANK_MATCH = 2'd0;
    localparam logic [RANK_W-1:0] RANK_EMPTY = 2'd1;
    localparam logic [RANK_W-1:0] RANK_OLD   = 2'd2;
    localparam logic [RANK_W-1:0] RANK_PAD   = 2'd3;

    typedef struct packed {
        logic [PID_IN_W-1:0]  proc_id;
        logic [PAGE_IN_W-1:0] page_num;
        logic [OFFSET_W-1:0]  page_offset;
    } t_req;

    typedef struct packed {
        logic [PHYS_W-1:0]      phys_addr;
        logic [FRAME_IDX_W-1:0] frame_idx;
        logic                   was_hit;
        logic                   offset_bad;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

// ===== design/inverted_page_table_lru.sv =====
// a taken request loads the leaf key registers, passes the registered levels of the
//   minimum tree, which resolves two levels of compare per cycle, and is committed to
//   the result register; no new request is taken until the result is committed
// a stalled result holds the sequencer in its commit state until the result is taken
// reset (synchronous, active low) clears all entry valid bits, the access counter,
//   the result valid flag, and sets frame_size to 4096; no clearing pass is needed
module inverted_page_table_lru #(
    parameter int NUM_FRAMES = 64,
    parameter int PID_BITS   = 16,
    parameter int PAGE_BITS  = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // address requests
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  iptl_pkg::t_req            i_in_data,
    // translated results
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output iptl_pkg::t_rsp            o_out_data,
    // frame_size register writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [iptl_pkg::CFG_W-1:0] i_cfg_data
);
    import iptl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register writes go straight into the frame_size register and are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: idle -> search (tree stages) -> commit
    iptl_ctrl #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // entries, per-entry match and age keys, min tree, stamp update, address math
    iptl_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .PID_BITS   (PID_BITS),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_rsp       (o_out_data),
        .o_rsp_valid (o_out_valid),
        .i_rsp_ready (i_out_ready)
    );

endmodule

// ===== design/iptl_min_tree.sv =====
// registered minimum tree over the per-entry search keys
module iptl_min_tree #(
    parameter int IDX_W = 6
) (
    input  logic                      i_clk,
    input  logic [iptl_pkg::KEY_W-1:0] i_leaf_key [1<<IDX_W],
    output logic [IDX_W-1:0]          o_idx,
    output logic                      o_hit
);
    import iptl_pkg::*;

    localparam int P = 1 << IDX_W;

    logic [KEY_W-1:0] v_key [1:2*P-1];
    logic [IDX_W-1:0] v_idx [1:2*P-1];

    for (genvar j = 0; j < P; j++) begin : g_leaf
        assign v_key[P+j] = i_leaf_key[j];
        assign v_idx[P+j] = IDX_W'(j);
    end

    for (genvar i = 1; i < P; i++) begin : g_node
        localparam int DEPTH  = $clog2(i + 1) - 1;
        localparam int HEIGHT = IDX_W - DEPTH;
        logic             sel_r;
        logic [KEY_W-1:0] n_key;
        logic [IDX_W-1:0] n_idx;

        // ties keep the left, lower-indexed child
        assign sel_r = v_key[2*i+1] < v_key[2*i];
        assign n_key = sel_r ? v_key[2*i+1] : v_key[2*i];
        assign n_idx = sel_r ? v_idx[2*i+1] : v_idx[2*i];

        if ((HEIGHT % 2 == 0) || (i == 1)) begin : g_reg
            logic [KEY_W-1:0] r_key;
            logic [IDX_W-1:0] r_idx;
            always_ff @(posedge i_clk) begin
                r_key <= n_key;
                r_idx <= n_idx;
            end
            assign v_key[i] = r_key;
            assign v_idx[i] = r_idx;
        end else begin : g_comb
            assign v_key[i] = n_key;
            assign v_idx[i] = n_idx;
        end
    end

    assign o_idx = v_idx[1];
    assign o_hit = (v_key[1][KEY_W-1 -: RANK_W] == RANK_MATCH);

endmodule

// ===== design/iptl_datapath.sv =====
// entry table, search keys, counter, address math and result register
module iptl_datapath #(
    parameter int NUM_FRAMES = 64,
    parameter int PID_BITS   = 16,
    parameter int PAGE_BITS  = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iptl_pkg::t_cmd            i_cmd,
    output iptl_pkg::t_sts            o_sts,
    input  iptl_pkg::t_req            i_req,
    input  logic                      i_cfg_valid,
    input  logic [iptl_pkg::CFG_W-1:0] i_cfg_data,
    output iptl_pkg::t_rsp            o_rsp,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready
);
    import iptl_pkg::*;

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int P      = 1 << IDX_W;
    localparam int PROD_W = IDX_W + CFG_W;
    localparam int SUM_W  = PROD_W + PHYS_W;

    logic                 r_valid [NUM_FRAMES];
    logic [PID_BITS-1:0]  r_pid   [NUM_FRAMES];
    logic [PAGE_BITS-1:0] r_page  [NUM_FRAMES];
    logic [STAMP_W-1:0]   r_stamp [NUM_FRAMES];
    logic [KEY_W-1:0]     r_leaf_key [P];
    logic [STAMP_W-1:0]   r_count;
    logic [CFG_W-1:0]     r_frame_size;
    t_req                 r_req;
    t_rsp                 r_rsp;
    logic                 r_rsp_valid;

    logic [PID_BITS-1:0]  in_pid;
    logic [PAGE_BITS-1:0] in_page;
    logic [PID_BITS-1:0]  req_pid;
    logic [PAGE_BITS-1:0] req_page;
    logic [IDX_W-1:0]     root_idx;
    logic                 root_hit;
    logic [STAMP_W-1:0]   n_count;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     sum;

    assign in_pid   = PID_BITS'(i_req.proc_id);
    assign in_page  = PAGE_BITS'(i_req.page_num);
    assign req_pid  = PID_BITS'(r_req.proc_id);
    assign req_page = PAGE_BITS'(r_req.page_num);

    // leaf keys built straight from the incoming request
    for (genvar j = 0; j < P; j++) begin : g_key
        logic [KEY_W-1:0] n_key;
        if (j < NUM_FRAMES) begin : g_real
            always_comb begin
                if (r_valid[j] && r_pid[j] == in_pid && r_page[j] == in_page) begin
                    n_key = {RANK_MATCH, {STAMP_W{1'b0}}};
                end else if (!r_valid[j]) begin
                    n_key = {RANK_EMPTY, {STAMP_W{1'b0}}};
                end else begin
                    n_key = {RANK_OLD, r_stamp[j]};
                end
            end
        end else begin : g_pad
            assign n_key = {RANK_PAD, {STAMP_W{1'b0}}};
        end
        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_leaf_key[j] <= n_key;
            end
        end
    end

    iptl_min_tree #(
        .IDX_W (IDX_W)
    ) u_tree (
        .i_clk      (i_clk),
        .i_leaf_key (r_leaf_key),
        .o_idx      (root_idx),
        .o_hit      (root_hit)
    );

    assign n_count = (r_count == STAMP_MAX) ? r_count : r_count + 1'b1;
    assign prod    = PROD_W'(root_idx) * PROD_W'(r_frame_size);
    assign sum     = SUM_W'(prod) + SUM_W'(r_req.page_offset);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.commit) begin
            r_rsp.phys_addr  <= PHYS_W'(sum);
            r_rsp.frame_idx  <= FRAME_IDX_W'(root_idx);
            r_rsp.was_hit    <= root_hit;
            r_rsp.offset_bad <= CFG_W'(r_req.page_offset) >= r_frame_size;
        end
    end

    for (genvar j = 0; j < NUM_FRAMES; j++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_cmd.commit && root_idx == IDX_W'(j)) begin
                r_stamp[j] <= n_count;
                if (!root_hit) begin
                    r_pid[j]  <= req_pid;
                    r_page[j] <= req_page;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_cmd.commit && root_idx == IDX_W'(j)) begin
                r_valid[j] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_frame_size <= FRAME_SIZE_RESET;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                r_frame_size <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_rsp_valid && !i_rsp_ready;
    assign o_rsp          = r_rsp;
    assign o_rsp_valid    = r_rsp_valid;

endmodule

// ===== design/iptl_ctrl.sv =====
// request sequencer: accept, wait for the search tree, commit
module iptl_ctrl #(
    parameter int NUM_FRAMES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  iptl_pkg::t_sts i_sts,
    output iptl_pkg::t_cmd o_cmd
);
    import iptl_pkg::*;

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int STAGES = (IDX_W + 1) / 2;
    localparam int CNT_W  = $clog2(STAGES + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_cnt == CNT_W'(STAGES - 1)) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPDATE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sim/inverted_page_table_lru_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the inverted page table with lru replacement
module inverted_page_table_lru_test;
    import iptl_pkg::*;

    localparam int FRAMES      = 64;
    localparam int POOL_DEPTH  = 128;
    localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake at all
    localparam int HOLD_AT     = 300;    // results seen before the long receiver hold
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;      // settling pause after the last result
    localparam int NUM_PLANS   = 7;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_req             i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_rsp             o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    inverted_page_table_lru uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the frame table
    bit                   frame_live  [FRAMES];
    logic [PID_IN_W-1:0]  frame_pid   [FRAMES];
    logic [PAGE_IN_W-1:0] frame_page  [FRAMES];
    logic [STAMP_W-1:0]   frame_stamp [FRAMES];
    logic [STAMP_W-1:0]   touch_count;
    logic [CFG_W-1:0]     frame_size_model;

    // requests waiting to be driven, translations waiting to come out
    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   outstanding;     // queued requests whose result has not been checked yet
    int   bad_count;
    int   results_seen;

    // key pool so that random traffic revisits pages and drives lru eviction
    logic [PID_IN_W-1:0]  key_pid  [POOL_DEPTH];
    logic [PAGE_IN_W-1:0] key_page [POOL_DEPTH];
    logic [CFG_W-1:0]     size_plan [NUM_PLANS];

    // translate one request and update the shadow table
    function automatic t_rsp translate(input t_req rq);
        int   slot;
        logic [63:0] phys;
        t_rsp rsp;
        slot = -1;
        // associative search, valid entries only
        for (int i = 0; i < FRAMES; i++)
            if (slot < 0 && frame_live[i] && frame_pid[i] == rq.proc_id &&
                frame_page[i] == rq.page_num)
                slot = i;
        rsp.was_hit = (slot >= 0);
        if (slot < 0) begin
            // lowest empty entry first
            for (int i = 0; i < FRAMES; i++)
                if (slot < 0 && !frame_live[i])
                    slot = i;
            // else smallest stamp, lowest index on a tie
            if (slot < 0) begin
                slot = 0;
                for (int i = 1; i < FRAMES; i++)
                    if (frame_stamp[i] < frame_stamp[slot])
                        slot = i;
            end
            frame_live[slot] = 1'b1;
            frame_pid[slot]  = rq.proc_id;
            frame_page[slot] = rq.page_num;
        end
        // saturating access counter
        if (touch_count != STAMP_MAX)
            touch_count = touch_count + 1'b1;
        frame_stamp[slot] = touch_count;
        // full product, low bits kept
        phys = 64'(slot) * 64'(frame_size_model) + 64'(rq.page_offset);
        rsp.phys_addr  = phys[PHYS_W-1:0];
        rsp.frame_idx  = FRAME_IDX_W'(slot);
        rsp.offset_bad = (17'(rq.page_offset) >= frame_size_model);
        return rsp;
    endfunction

    // idle length: mostly none or short, a few long, with calm stretches
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(999);
        if (r < 15) begin
            calm = $urandom_range(100, 30);
            return 0;
        end
        if (r < 550)
            return 0;
        if (r < 900)
            return $urandom_range(3, 1);
        if (r < 985)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // offsets: in range, at the boundary, or anything
    function automatic logic [OFFSET_W-1:0] pick_offset();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 && frame_size_model > 1 && frame_size_model <= 17'd65536)
            return OFFSET_W'($urandom_range(frame_size_model - 1));
        if (r < 65 && frame_size_model > 0 && frame_size_model <= 17'd65536)
            return OFFSET_W'(frame_size_model - 1 + $urandom_range(1));
        return OFFSET_W'($urandom_range(65535));
    endfunction

    task automatic queue_req(input logic [PID_IN_W-1:0] pid,
                             input logic [PAGE_IN_W-1:0] page,
                             input logic [OFFSET_W-1:0] offset);
        t_req rq;
        rq.proc_id     = pid;
        rq.page_num    = page;
        rq.page_offset = offset;
        outstanding++;
        pending_reqs.push_back(rq);
    endtask

    // mostly pool keys, some near misses one bit away, some fresh keys
    task automatic queue_random(input int count, input int span);
        int unsigned          r;
        int                   k;
        int                   b;
        logic [PID_IN_W-1:0]  pid;
        logic [PAGE_IN_W-1:0] page;
        for (int n = 0; n < count; n++) begin
            r    = $urandom_range(99);
            k    = $urandom_range(span - 1);
            pid  = key_pid[k];
            page = key_page[k];
            if (r >= 75 && r < 87) begin
                if ($urandom_range(1)) begin
                    b = $urandom_range(PID_IN_W - 1);
                    pid[b] = ~pid[b];
                end else begin
                    b = $urandom_range(PAGE_IN_W - 1);
                    page[b] = ~page[b];
                end
            end else if (r >= 87) begin
                pid  = PID_IN_W'($urandom);
                page = PAGE_IN_W'($urandom);
            end
            queue_req(pid, page, pick_offset());
        end
    endtask

    // sender pause: let every result come out, then let the pipe settle
    task automatic wait_idle();
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_frame_size(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        // taken at this edge
        i_cfg_valid      <= 1'b0;
        frame_size_model = value;
    endtask

    // request driver, fed from pending_reqs
    int unsigned send_gap;
    int unsigned send_calm;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap  = 0;
            send_calm = 0;
        end else begin
            // predict at acceptance, the table state follows accepted order
            if (i_in_valid && o_in_ready)
                expected_rsps.push_back(translate(i_in_data));
            // a request still waiting keeps valid and data as they are
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_reqs.pop_front();
                    send_gap   = pick_gap(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver backpressure
    int unsigned recv_gap;
    int unsigned recv_calm;
    int unsigned hold_left;
    bit          hold_done;
    t_rsp        want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap  = 0;
            recv_calm = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result phys=%h idx=%0d hit=%b bad=%b",
                                 o_out_data.phys_addr, o_out_data.frame_idx,
                                 o_out_data.was_hit, o_out_data.offset_bad);
                end else begin
                    want = expected_rsps.pop_front();
                    outstanding--;
                    results_seen++;
                    if (want.phys_addr !== o_out_data.phys_addr ||
                        want.frame_idx !== o_out_data.frame_idx ||
                        want.was_hit !== o_out_data.was_hit ||
                        want.offset_bad !== o_out_data.offset_bad) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("mismatch exp phys=%h idx=%0d hit=%b bad=%b, got phys=%h idx=%0d hit=%b bad=%b",
                                     want.phys_addr, want.frame_idx, want.was_hit,
                                     want.offset_bad, o_out_data.phys_addr,
                                     o_out_data.frame_idx, o_out_data.was_hit,
                                     o_out_data.offset_bad);
                    end
                end
            end
            // one long hold while the sender keeps offering, then random stalls
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap = pick_gap(recv_calm);
            end
        end
    end

    // watchdog on cycles with no handshake
    int unsigned quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // known values on every input from time zero
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        outstanding = 0;
        bad_count   = 0;
        results_seen = 0;
        hold_done   = 1'b0;
        // shadow table after reset
        for (int i = 0; i < FRAMES; i++) begin
            frame_live[i]  = 1'b0;
            frame_pid[i]   = '0;
            frame_page[i]  = '0;
            frame_stamp[i] = '0;
        end
        touch_count      = '0;
        frame_size_model = FRAME_SIZE_RESET;
        for (int k = 0; k < POOL_DEPTH; k++) begin
            key_pid[k]  = PID_IN_W'($urandom);
            key_page[k] = PAGE_IN_W'($urandom);
        end
        key_pid[0]  = '0;
        key_page[0] = '0;
        key_pid[1]  = '1;
        key_page[1] = '1;
        size_plan = '{17'd1, 17'd65536, 17'd0, 17'h1FFFF,
                      CFG_W'($urandom_range(300, 2)),
                      CFG_W'($urandom_range(131071, 300)), FRAME_SIZE_RESET};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset frame size
        queue_req('0, '0, '0);                 // empty entry must not match pid 0 page 0
        queue_req('0, '0, 16'd4095);           // hit, last in-range offset
        queue_req('0, '0, 16'd4096);           // hit, offset just out of range
        queue_req('1, '1, '1);                 // all ones key and offset
        queue_req('1, '0, 16'd1);              // pid matches, page does not
        queue_req('0, '1, 16'd2);              // page matches, pid does not
        queue_req('1, '1, '0);                 // hit on the all ones key
        queue_req(16'd1, '0, '0);              // one bit off in pid
        queue_req('0, 20'd1, '0);              // one bit off in page
        queue_req('0, '0, '0);                 // hit again, restamps entry 0
        queue_req(16'hAAAA, 20'hAAAAA, 16'hAAAA);
        queue_req(16'h5555, 20'h55555, 16'h5555);
        queue_req(16'h5555, 20'h55555, 16'h0000);
        queue_req(16'h8000, 20'h80000, 16'h8000);
        queue_random(180, 100);
        wait_idle();

        // each phase writes frame_size while idle, then random traffic
        for (int p = 0; p < NUM_PLANS; p++) begin
            write_frame_size(size_plan[p]);
            queue_random(125, $urandom_range(110, 40));
            wait_idle();
        end

        while (outstanding != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (bad_count == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
